### rtl/tss_pkg.sv
// Shared types, character codes and helpers for the token splitter.
`timescale 1ns / 1ps
package tss_pkg;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OP   = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } res_t;

  // One queue entry: up to four results and the index of the last one.
  typedef struct packed {
    logic [1:0]       last;
    res_t [3:0]       res;
  } entry_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h3d) || (c == 8'h2a) ||
           (c == CH_SLASH) || (c == 8'h3a) || (c == 8'h24) || (c == 8'h28) ||
           (c == 8'h29) || (c == 8'h2c);
  endfunction

endpackage

### rtl/tss_front.sv
// Front end: accepts source words, tracks lexer state and builds result groups.
`timescale 1ns / 1ps
module tss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_ch,
  input  logic              in_is_final,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output tss_pkg::entry_t   q_entry
);

  logic tok_r, tok_nxt;
  logic quote_r, quote_nxt;
  logic cmt_r, cmt_nxt;
  logic slash_r, slash_nxt;
  logic accept;
  logic [2:0] k;
  tss_pkg::entry_t e;
  logic c_ws;
  logic c_op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c_ws     = tss_pkg::is_ws(in_ch);
  assign c_op     = tss_pkg::is_op(in_ch);

  always_comb begin
    e         = '0;
    k         = 3'd0;
    tok_nxt   = tok_r;
    quote_nxt = quote_r;
    cmt_nxt   = cmt_r;
    slash_nxt = slash_r;
    if (cmt_r) begin
      if (in_ch == tss_pkg::CH_NL) cmt_nxt = 1'b0;
      if (in_is_final && tok_nxt) begin
        e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
        k = k + 3'd1;
        tok_nxt = 1'b0;
      end
    end else if (slash_r && in_ch == tss_pkg::CH_SLASH) begin
      slash_nxt = 1'b0;
      cmt_nxt   = 1'b1;
      if (in_is_final && tok_nxt) begin
        e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
        k = k + 3'd1;
        tok_nxt = 1'b0;
      end
    end else begin
      // A held slash that did not start a comment is an operator token.
      if (slash_r) begin
        slash_nxt = 1'b0;
        if (tok_nxt) begin
          e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
          k = k + 3'd1;
          tok_nxt = 1'b0;
        end
        e.res[k[1:0]] = '{tss_pkg::KIND_OP, tss_pkg::CH_SLASH};
        k = k + 3'd1;
      end
      if (in_ch == tss_pkg::CH_SLASH && !in_is_final) begin
        slash_nxt = 1'b1;
      end else if (in_ch == tss_pkg::CH_QUOTE) begin
        quote_nxt = !quote_nxt;
        if (in_is_final && tok_nxt) begin
          e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
          k = k + 3'd1;
          tok_nxt = 1'b0;
        end
      end else if (in_is_final) begin
        if (!(c_ws && !quote_nxt && !tok_nxt)) begin
          e.res[k[1:0]] = '{tss_pkg::KIND_BYTE, in_ch};
          k = k + 3'd1;
          e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
          k = k + 3'd1;
          tok_nxt = 1'b0;
        end
      end else if (c_ws) begin
        if (quote_nxt) begin
          e.res[k[1:0]] = '{tss_pkg::KIND_BYTE, in_ch};
          k = k + 3'd1;
          tok_nxt = 1'b1;
        end else if (tok_nxt) begin
          e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
          k = k + 3'd1;
          tok_nxt = 1'b0;
        end
      end else if (c_op) begin
        if (tok_nxt) begin
          e.res[k[1:0]] = '{tss_pkg::KIND_END, 8'd0};
          k = k + 3'd1;
          tok_nxt = 1'b0;
        end
        e.res[k[1:0]] = '{tss_pkg::KIND_OP, in_ch};
        k = k + 3'd1;
      end else begin
        e.res[k[1:0]] = '{tss_pkg::KIND_BYTE, in_ch};
        k = k + 3'd1;
        tok_nxt = 1'b1;
      end
    end
    // The end of the text returns everything to its reset value.
    if (in_is_final) begin
      tok_nxt   = 1'b0;
      quote_nxt = 1'b0;
      cmt_nxt   = 1'b0;
      slash_nxt = 1'b0;
    end
    e.last = k[1:0] - 2'd1;
  end

  assign q_push  = accept && (k != 3'd0);
  assign q_entry = e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      quote_r <= 1'b0;
      cmt_r   <= 1'b0;
      slash_r <= 1'b0;
    end else if (accept) begin
      tok_r   <= tok_nxt;
      quote_r <= quote_nxt;
      cmt_r   <= cmt_nxt;
      slash_r <= slash_nxt;
    end
  end

endmodule

### rtl/tss_queue.sv
// Short queue of result groups between the front and back ends.
`timescale 1ns / 1ps
module tss_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tss_pkg::entry_t  push_entry,
  input  logic             pop,
  output tss_pkg::entry_t  head,
  output logic             full,
  output logic             empty
);

  tss_pkg::entry_t mem [tss_pkg::QDEPTH];
  logic [tss_pkg::QAW-1:0] wptr_r;
  logic [tss_pkg::QAW-1:0] rptr_r;
  logic [tss_pkg::QAW:0]   cnt_r;

  assign full  = (cnt_r == (tss_pkg::QAW+1)'(tss_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### rtl/tss_back.sv
// Back end: unpacks result groups into one output word per cycle while out_stall is low.
`timescale 1ns / 1ps
module tss_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tss_pkg::entry_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_value,
  output logic             out_last_of_run,
  input  logic             out_stall
);

  logic       valid_r;
  logic [1:0] idx_r;
  logic [1:0] kind_r;
  logic [7:0] value_r;
  logic       last_r;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!valid_r || !out_stall);
  assign at_last = (idx_r == head.last);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= head.res[idx_r].kind;
      value_r <= head.res[idx_r].value;
      last_r  <= at_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_value       = value_r;
  assign out_last_of_run = last_r;

endmodule

### rtl/token_splitter_stream.sv
// Top level of the streaming token splitter.
`timescale 1ns / 1ps
// The block takes one source byte per cycle while in_stall is low and streams
// out token bytes, end-of-token marks and operator tokens. The front end
// classifies each word in the cycle it is accepted and writes its results, up
// to four, as one group into a four-entry queue; the back end sends one result
// word per cycle while out_stall is low from that queue through an output
// register. in_stall rises only when the queue is full. Bytes that yield no
// result (held slashes, quote marks, comment text) never enter the queue.
module token_splitter_stream (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_ch,
  input  logic       in_is_final,
  output logic       in_stall,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last_of_run,
  input  logic       out_stall
);

  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  tss_pkg::entry_t q_in;
  tss_pkg::entry_t q_head;

  tss_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ch       (in_ch),
    .in_is_final (in_is_final),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  tss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  tss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_stall       (out_stall)
  );

`ifndef SYNTHESIS
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty)) else $error("queue reports full and empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into a full queue");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind != 2'd3)) else $error("illegal result kind");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == tss_pkg::KIND_END) |-> (out_value == 8'd0))
    else $error("end-of-token word carries a value");
`endif

endmodule

### tb/token_splitter_stream_tb.sv
// Self-checking testbench for the streaming token splitter.
`timescale 1ns / 1ps
module token_splitter_stream_tb;

  localparam int RANDOM_WORDS = 226;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AT_A = 20;
  localparam int HOLD_AT_B = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam string OPERATORS = "+-=*/:$(),";

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } tok_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic [3:0] gap;
    logic       drain;
  } src_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic       in_is_final = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_last_of_run;
  logic       out_stall = 1'b0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  src_word_t pending_words[$];
  tok_res_t  expected_tokens[$];
  tok_res_t  run_buf[4];
  int        run_n;

  // Lexer state as the block should hold it.
  logic lx_has_bytes = 1'b0;
  logic lx_quote = 1'b0;
  logic lx_comment = 1'b0;
  logic lx_slash = 1'b0;

  int words_built = 0;
  int words_in = 0;
  int results_seen = 0;
  int texts_ended = 0;
  int fail_count = 0;
  int tx_gap = 0;
  bit tx_armed = 1'b0;
  int rx_wait = 0;

  token_splitter_stream DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ch(in_ch),
    .in_is_final(in_is_final),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_value(out_value),
    .out_last_of_run(out_last_of_run),
    .out_stall(out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_white(input logic [7:0] c);
    return c == tss_pkg::CH_SPACE || c == tss_pkg::CH_TAB || c == tss_pkg::CH_NL;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < OPERATORS.len(); i++) begin
      if (c == OPERATORS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic push_res(input logic [1:0] k, input logic [7:0] v);
    if (run_n < 4) begin
      run_buf[run_n].kind = k;
      run_buf[run_n].value = v;
      run_buf[run_n].last = 1'b0;
      run_n++;
    end
  endtask

  task automatic close_open_token();
    if (lx_has_bytes) begin
      push_res(tss_pkg::KIND_END, 8'h00);
      lx_has_bytes = 1'b0;
    end
  endtask

  task automatic lex_char(input logic [7:0] c, input logic fin);
    logic ws;
    ws = is_white(c);
    if (c == tss_pkg::CH_QUOTE) begin
      lx_quote = !lx_quote;
      if (fin) close_open_token();
    end else if (fin) begin
      // An unquoted blank at the very end is dropped unless a token is open.
      if (!(ws && !lx_quote && !lx_has_bytes)) begin
        push_res(tss_pkg::KIND_BYTE, c);
        push_res(tss_pkg::KIND_END, 8'h00);
        lx_has_bytes = 1'b0;
      end
    end else if (ws) begin
      if (lx_quote) begin
        push_res(tss_pkg::KIND_BYTE, c);
        lx_has_bytes = 1'b1;
      end else begin
        close_open_token();
      end
    end else if (is_operator(c)) begin
      close_open_token();
      push_res(tss_pkg::KIND_OP, c);
    end else begin
      push_res(tss_pkg::KIND_BYTE, c);
      lx_has_bytes = 1'b1;
    end
  endtask

  // Works out the token words one source byte causes and queues them.
  task automatic lex_predict(input logic [7:0] c, input logic fin);
    run_n = 0;
    if (lx_comment) begin
      if (c == tss_pkg::CH_NL) lx_comment = 1'b0;
      if (fin) close_open_token();
    end else if (lx_slash && c == tss_pkg::CH_SLASH) begin
      lx_slash = 1'b0;
      lx_comment = 1'b1;
      if (fin) close_open_token();
    end else begin
      // A held slash that did not start a comment is an operator after all.
      if (lx_slash) begin
        lx_slash = 1'b0;
        lex_char(tss_pkg::CH_SLASH, 1'b0);
      end
      if (c == tss_pkg::CH_SLASH && !fin) lx_slash = 1'b1;
      else lex_char(c, fin);
    end
    if (fin) begin
      lx_has_bytes = 1'b0;
      lx_quote = 1'b0;
      lx_comment = 1'b0;
      lx_slash = 1'b0;
    end
    if (run_n > 0) run_buf[run_n - 1].last = 1'b1;
    for (int i = 0; i < run_n; i++) expected_tokens.push_back(run_buf[i]);
  endtask

  task automatic add_word(input logic [7:0] c, input logic fin, input logic drain);
    src_word_t w;
    w.ch = c;
    w.fin = fin;
    w.drain = drain;
    // A stretch of source bytes is offered back to back.
    if (words_built >= 110 && words_built < 160) w.gap = 4'd0;
    else w.gap = 4'($urandom_range(0, 9));
    pending_words.push_back(w);
    words_built++;
  endtask

  task automatic add_text(input string s, input logic fin_at_end, input logic drain);
    for (int i = 0; i < s.len(); i++) begin
      add_word(s[i], fin_at_end && i == s.len() - 1, drain && i == 0);
    end
  endtask

  function automatic logic [7:0] draw_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 45) return 8'h30 + 8'($urandom_range(0, 9));
    else if (r < 52) return tss_pkg::CH_SPACE;
    else if (r < 56) return tss_pkg::CH_TAB;
    else if (r < 61) return tss_pkg::CH_NL;
    else if (r < 74) return OPERATORS[$urandom_range(0, 9)];
    else if (r < 82) return tss_pkg::CH_SLASH;
    else if (r < 88) return tss_pkg::CH_QUOTE;
    else return 8'($urandom_range(0, 255));
  endfunction

  // Sender: holds a word until it is taken, then waits out the next word's gap.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_valid) begin
          void'(pending_words.pop_front());
          tx_armed = 1'b0;
        end
        if (!tx_armed && pending_words.size() != 0) begin
          tx_gap = pending_words[0].gap;
          tx_armed = 1'b1;
        end
        if (tx_armed && tx_gap == 0 &&
            !(pending_words[0].drain && expected_tokens.size() != 0)) begin
          in_valid <= 1'b1;
          in_ch <= pending_words[0].ch;
          in_is_final <= pending_words[0].fin;
        end else begin
          in_valid <= 1'b0;
          if (tx_armed && tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  // Receiver: a random wait after each word, none in one stretch, and two long
  // hold-offs that let the block fill up and push back on its input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) rx_wait = HOLD_CYCLES;
        else if (results_seen >= 140 && results_seen < 230) rx_wait = 0;
        else rx_wait = $urandom_range(0, 9);
      end
      out_stall <= (rx_wait != 0);
      if (rx_wait != 0) rx_wait--;
    end
  end

  always @(posedge clk) begin
    tok_res_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_tokens.size() == 0) begin
          $error("unexpected word: kind %0d value 0x%02h last %0d",
                 out_kind, out_value, out_last_of_run);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_value !== want.value) begin
            $error("value: expected 0x%02h, got 0x%02h", want.value, out_value);
            fail_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        words_in++;
        if (in_is_final) texts_ended++;
        lex_predict(in_ch, in_is_final);
      end
    end
  end

  initial begin
    // Tokens closed by blanks and by an operator, then every other operator in a
    // row, with a held slash that turns out to be an operator.
    add_text("a \t\nb+", 1'b0, 1'b0);
    add_text("-=*:$(),/x", 1'b0, 1'b0);
    add_word(8'hff, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);
    // A quoted tab is kept as a token byte.
    add_text("@\t@", 1'b0, 1'b0);
    // The text ends inside a comment, with a token still open.
    add_text("//q", 1'b1, 1'b1);
    add_text("k ", 1'b1, 1'b0);
    add_text(" ", 1'b1, 1'b0);
    add_text("m@", 1'b1, 1'b0);
    add_text("a//", 1'b1, 1'b0);
    add_text("+", 1'b1, 1'b0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      add_word(draw_char(), $urandom_range(0, 17) == 0, i == 150);
    end
    add_word(draw_char(), 1'b1, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0);
    wait (expected_tokens.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d source bytes in %0d texts and %0d token words,",
             words_in, texts_ended, results_seen);
    $display("with random gaps on both sides and two long output hold-offs.");
    if (fail_count == 0) begin
      $display("[token_splitter_stream] OK");
    end else begin
      $display("[token_splitter_stream] ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d token words still expected.", expected_tokens.size());
    $display("[token_splitter_stream] ERROR");
    $finish;
  end

endmodule
